FILE: src/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg: shared definitions for the button debouncer
// Register indexes, reset values and field widths of the debounce and
// long-press detector.
// ----------------------------------------------------------------------------
package bdlp_pkg;

	// default width of the millisecond counters
	localparam int TIME_BITS_DEF = 16;

	// field widths
	localparam int LEVEL_W   = 1;
	localparam int LONG_W    = 16;
	localparam int DEB_W     = 10;
	localparam int PIN_W     = 6;
	localparam int LEN_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int S_DATA_W  = 8;
	localparam int M_DATA_W  = 24;

	// register reset values
	localparam logic              ACTIVE_LEVEL_RST = 1'b0;
	localparam logic [LONG_W-1:0] LONG_PRESS_RST   = 16'd1000;
	localparam logic              IMMEDIATE_RST    = 1'b0;
	localparam logic [DEB_W-1:0]  DEBOUNCE_RST     = 10'd50;
	localparam logic [PIN_W-1:0]  PIN_ID_RST       = 6'd0;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_LEVEL = 3'd0,
		REG_LONG_PRESS   = 3'd1,
		REG_IMMEDIATE    = 3'd2,
		REG_DEBOUNCE     = 3'd3,
		REG_PIN_ID       = 3'd4
	} cfg_reg_t;

endpackage

FILE: src/button_debounce_long_press_core.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_core: push-button debouncer with long press
// Takes one sampled pin level per millisecond tick and reports each press
// with its length and a long-press flag.
// ----------------------------------------------------------------------------
// Each transfer on the s_ side is one millisecond tick carrying the sampled
// pin level. The block takes one tick per clock cycle whenever the result
// register is free or being drained in the same cycle; the whole tick update
// (elapsed time, debounce timer, edge detection) is one pass of logic from
// the state registers into the result register, so a result, when the tick
// causes one, is on m_ in the cycle after the tick's transfer. A tick causes at
// most one result. Edges are ignored from each accepted edge until the
// debounce timer expires; in immediate mode a long press is reported once
// the limit is reached while still held. Configuration writes are taken in
// any cycle (cfg_ready is always high) and must be made while idle.
// ----------------------------------------------------------------------------
module button_debounce_long_press_core #(
	parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// tick input; s_tdata: [0] pin_level, [7:1] zero
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bdlp_pkg::S_DATA_W-1:0]    s_tdata,
	// press reports; m_tdata: [5:0] pin_number, [21:6] press_len,
	// [22] long_flag, [23] zero
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bdlp_pkg::M_DATA_W-1:0]    m_tdata,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bdlp_pkg::CFG_DAT_W-1:0]   cfg_data
);

	localparam int WIDE_W = 33;
	localparam logic [WIDE_W-1:0] TIME_MAX_W =
		(WIDE_W'(1) << TIME_BITS) - WIDE_W'(1);
	localparam logic [TIME_BITS-1:0] TIME_MAX = TIME_MAX_W[TIME_BITS-1:0];
	localparam logic [WIDE_W-1:0] LEN_MAX_W =
		(WIDE_W'(1) << bdlp_pkg::LEN_W) - WIDE_W'(1);

	// configuration registers
	logic                            active_level_q;
	logic [bdlp_pkg::LONG_W-1:0]     long_press_q;
	logic                            immediate_q;
	logic [bdlp_pkg::DEB_W-1:0]      debounce_q;
	logic [bdlp_pkg::PIN_W-1:0]      pin_id_q;

	// tick state
	logic                            held_q;
	logic [TIME_BITS-1:0]            elapsed_q;
	logic [TIME_BITS-1:0]            timer_q;
	logic                            running_q;
	logic                            masked_q;
	logic                            last_level_q;

	// result register
	logic [bdlp_pkg::PIN_W-1:0]      out_pin_q;
	logic [bdlp_pkg::LEN_W-1:0]      out_len_q;
	logic                            out_long_q;

	// next-state values of one tick
	logic                            held_d;
	logic [TIME_BITS-1:0]            elapsed_d;
	logic [TIME_BITS-1:0]            timer_d;
	logic                            running_d;
	logic                            masked_d;
	logic                            report;
	logic [bdlp_pkg::LEN_W-1:0]      rep_len;
	logic                            rep_long;

	logic                            accept;
	logic                            level;

	// Clamp a timer load value to 1 .. TIME_MAX.
	function automatic logic [TIME_BITS-1:0] arm_value(input logic [bdlp_pkg::LONG_W-1:0] v);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(v);
		if (w == '0) begin
			w = WIDE_W'(1);
		end
		if (w > TIME_MAX_W) begin
			w = TIME_MAX_W;
		end
		return w[TIME_BITS-1:0];
	endfunction

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = !m_tvalid || m_tready;
	assign cfg_ready = 1'b1;
	assign level     = s_tdata[0];
	assign m_tdata   = {1'b0, out_long_q, out_len_q, out_pin_q};

	// Tick update: advance time, handle timer expiry, then edge detection
	always_comb begin
		logic               active;
		logic               expired;
		logic [WIDE_W-1:0]  e_wide;
		active   = (level == active_level_q);
		expired  = 1'b0;
		report   = 1'b0;
		rep_len  = '0;
		rep_long = 1'b0;
		held_d   = held_q;
		masked_d = masked_q;

		// advance elapsed time, saturating
		elapsed_d = (elapsed_q != TIME_MAX) ? elapsed_q + TIME_BITS'(1) : elapsed_q;

		// count the one-shot timer down
		timer_d   = timer_q;
		running_d = running_q;
		if (running_q) begin
			if (timer_q != '0) begin
				timer_d = timer_q - TIME_BITS'(1);
			end
			if (timer_d == '0) begin
				running_d = 1'b0;
				expired   = 1'b1;
			end
		end

		e_wide = WIDE_W'(elapsed_d);

		// expiry: report a release or rearm for the long-press limit
		if (expired) begin
			if (!active || e_wide >= WIDE_W'(long_press_q)) begin
				if (held_d) begin
					report    = 1'b1;
					rep_len   = (e_wide > LEN_MAX_W) ? '1 : e_wide[bdlp_pkg::LEN_W-1:0];
					rep_long  = 1'b1 & (e_wide >= WIDE_W'(long_press_q));
					held_d    = 1'b0;
					elapsed_d = '0;
					running_d = 1'b0;
				end
			end else if (immediate_q &&
					long_press_q > bdlp_pkg::LONG_W'(debounce_q)) begin
				timer_d   = arm_value(long_press_q - bdlp_pkg::LONG_W'(debounce_q));
				running_d = 1'b1;
			end
			masked_d = 1'b0;
		end

		e_wide = WIDE_W'(elapsed_d);

		// edge: press starts timing, release reports
		if (level != last_level_q && !masked_d) begin
			masked_d = 1'b1;
			if (active) begin
				held_d    = 1'b1;
				elapsed_d = '0;
			end else if (!report && held_d) begin
				report    = 1'b1;
				rep_len   = (e_wide > LEN_MAX_W) ? '1 : e_wide[bdlp_pkg::LEN_W-1:0];
				rep_long  = (e_wide >= WIDE_W'(long_press_q));
				held_d    = 1'b0;
				elapsed_d = '0;
			end
			timer_d   = arm_value(bdlp_pkg::LONG_W'(debounce_q));
			running_d = 1'b1;
		end
	end

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q <= bdlp_pkg::ACTIVE_LEVEL_RST;
			long_press_q   <= bdlp_pkg::LONG_PRESS_RST;
			immediate_q    <= bdlp_pkg::IMMEDIATE_RST;
			debounce_q     <= bdlp_pkg::DEBOUNCE_RST;
			pin_id_q       <= bdlp_pkg::PIN_ID_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (bdlp_pkg::cfg_reg_t'(cfg_index))
				bdlp_pkg::REG_ACTIVE_LEVEL: active_level_q <= cfg_data[0];
				bdlp_pkg::REG_LONG_PRESS:   long_press_q   <= cfg_data;
				bdlp_pkg::REG_IMMEDIATE:    immediate_q    <= cfg_data[0];
				bdlp_pkg::REG_DEBOUNCE:     debounce_q     <= cfg_data[bdlp_pkg::DEB_W-1:0];
				bdlp_pkg::REG_PIN_ID:       pin_id_q       <= cfg_data[bdlp_pkg::PIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Tick state: update on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= 1'b0;
			elapsed_q    <= '0;
			timer_q      <= '0;
			running_q    <= 1'b0;
			masked_q     <= 1'b0;
			last_level_q <= ~bdlp_pkg::ACTIVE_LEVEL_RST;
		end else if (accept) begin
			held_q       <= held_d;
			elapsed_q    <= elapsed_d;
			timer_q      <= timer_d;
			running_q    <= running_d;
			masked_q     <= masked_d;
			last_level_q <= level;
		end
	end

	// Result register: load on a report, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (accept && report) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (accept && report) begin
			out_pin_q  <= pin_id_q;
			out_len_q  <= rep_len;
			out_long_q <= rep_long;
		end
	end

	// a report needs a held button
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && report |-> held_q)
		else $error("press report without held button");

	// a report restarts the elapsed count (a new press may follow in the same tick)
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && report |=> elapsed_q == '0)
		else $error("elapsed time not cleared after report");

	// a running timer never sits at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> timer_q != '0)
		else $error("running timer at zero");

	// a waiting result blocks new ticks
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("tick taken while result stalled");

endmodule
